@@ rtl/core/itda_pkg.sv @@
// Shared package for the integer to decimal ASCII converter.
// Holds the default word width, character codes, op codes, sizing helpers and
// the front-end state type. Depends on nothing.
package itda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int BITS_PER_STEP  = 4;
  localparam int OUT_TDATA_W    = 16;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

  // Op carried in tuser: how the word is read.
  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // Decimal digits needed for 2**vb - 1, using log10(2) ~ 1233/4096.
  function automatic int num_digits(input int vb);
    return ((vb * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_t;

endpackage

@@ rtl/core/itda_front.sv @@
// Front end of the converter: accepts a word, forms its magnitude and
// converts it to BCD with a shift-and-add-3 unit, four bits per cycle.
// Depends on itda_pkg.
module itda_front
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8,
  localparam int ND         = num_digits(VALUE_BITS),
  localparam int NDW        = $clog2(ND + 1),
  localparam int QW         = 1 + NDW + ND * 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // value
  input  logic                  in_tuser,  // op
  output logic                  q_push,
  input  logic                  q_ready,
  output logic [QW-1:0]         q_data     // bcd digits, digit count, sign
);

  localparam int CYC  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHW  = CYC * BITS_PER_STEP;
  localparam int CNTW = $clog2(CYC);

  front_state_t            state_r, state_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [SHW-1:0]          shr_r, shr_nxt;
  logic [ND*4-1:0]         bcd_r, bcd_nxt, bcd_step;
  logic                    neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]   word;
  logic [VALUE_BITS-1:0]   mag;
  logic                    neg_in;
  logic [NDW-1:0]          ndig;
  logic                    accept;

  assign accept = in_tvalid && in_tready;
  assign word   = in_tdata[VALUE_BITS-1:0];
  assign neg_in = (in_tuser == OP_SIGNED) && word[VALUE_BITS-1];
  assign mag    = neg_in ? (~word + VALUE_BITS'(1)) : word;

  // Four shift-and-add-3 steps on the BCD vector, fed from the top of the
  // magnitude shift register.
  always_comb begin
    bcd_step = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[ND*4-2:0], shr_r[SHW-1-s]};
    end
  end

  // Number of significant digits; zero still prints one digit.
  always_comb begin
    ndig = NDW'(1);
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        ndig = NDW'(d + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (accept) state_nxt = FR_CONV;
      end
      FR_CONV: begin
        if (cnt_r == CNTW'(CYC - 1)) state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (q_ready) state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    q_push    = 1'b0;
    cnt_nxt   = cnt_r;
    shr_nxt   = shr_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    case (state_r)
      FR_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          cnt_nxt = '0;
          shr_nxt = SHW'(mag);
          bcd_nxt = '0;
          neg_nxt = neg_in;
        end
      end
      FR_CONV: begin
        bcd_nxt = bcd_step;
        shr_nxt = shr_r << BITS_PER_STEP;
        cnt_nxt = cnt_r + CNTW'(1);
      end
      FR_PUSH: begin
        q_push = q_ready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign q_data = {neg_r, ndig, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    shr_r <= shr_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FR_CONV |-> cnt_r <= CNTW'(CYC - 1))
    else $error("conversion step count ran past the word");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == FR_CONV && cnt_r == '0)
    else $error("accepted item did not start a conversion");

endmodule

@@ rtl/core/itda_queue.sv @@
// Small register queue between the converter front end and the emitter.
// Depends on itda_pkg for its depth.
module itda_queue
  import itda_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign push_ready = count_r != CW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue read while empty");

endmodule

@@ rtl/core/itda_back.sv @@
// Back end of the converter: takes converted numbers from the queue and
// emits one ASCII character per item through a registered output stage.
// Depends on itda_pkg.
module itda_back
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ND  = num_digits(VALUE_BITS),
  localparam int NDW = $clog2(ND + 1),
  localparam int QW  = 1 + NDW + ND * 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [QW-1:0]          q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ascii_char, char_count
  output logic                   out_tlast
);

  localparam int IDXW = $clog2(ND);
  localparam int TW   = $clog2(ND + 2);

  logic                busy_r, busy_nxt;
  logic                minus_r, minus_nxt;
  logic [IDXW-1:0]     idx_r, idx_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [ND*4-1:0]     bcd_r, bcd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                q_neg;
  logic [NDW-1:0]      q_ndig;
  logic [ND*4-1:0]     q_bcd;
  logic                emit;
  logic [3:0]          digit;

  assign {q_neg, q_ndig, q_bcd} = q_data;
  assign q_pop = !busy_r && q_valid;
  assign emit  = busy_r && (!out_valid_r || out_tready);
  assign digit = bcd_r[idx_r*4 +: 4];

  always_comb begin
    busy_nxt      = busy_r;
    minus_nxt     = minus_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      minus_nxt = q_neg;
      idx_nxt   = IDXW'(q_ndig - NDW'(1));
      total_nxt = TW'(q_ndig) + TW'(q_neg);
      bcd_nxt   = q_bcd;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = COUNT_W'(total_r);
      if (minus_r) begin
        out_char_nxt = CH_MINUS;
        out_last_nxt = total_r == TW'(1);
        minus_nxt    = 1'b0;
      end else begin
        out_char_nxt = CH_ZERO + CHAR_W'(digit);
        out_last_nxt = idx_r == '0;
        if (idx_r == '0) busy_nxt = 1'b0;
        else idx_nxt = idx_r - IDXW'(1);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_char_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      minus_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      minus_r     <= minus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    bcd_r       <= bcd_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !minus_r && idx_r == '0 |=> !busy_r && out_tvalid && out_tlast)
    else $error("final digit did not end the number");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    emit && minus_r |=> out_tvalid && out_char_r == CH_MINUS && !out_tlast)
    else $error("sign character not emitted first");

endmodule

@@ rtl/core/integer_to_decimal_ascii.sv @@
// Integer to decimal ASCII converter, top level. Each input item is a word and
// an op (tuser: 0 = signed, 1 = unsigned); the block returns its decimal text
// as one output item per character, most significant digit first, with a
// leading '-' for negative signed values, tlast on the final character and
// the total character count beside every character. The front end converts a
// word with its shift-and-add-3 unit, four bits per step, between an accept
// state and a hand-off state, and takes no new word until the last is handed
// off; the back end emits one character per cycle while out_tready allows,
// after loading each number from the queue, and the two overlap through a
// two-entry queue.
module integer_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ascii_char[6:0], char_count[10:7]
  output logic                   out_tlast
);

  localparam int ND  = num_digits(VALUE_BITS);
  localparam int NDW = $clog2(ND + 1);
  localparam int QW  = 1 + NDW + ND * 4;

  logic          push, push_ready, pop, pop_valid;
  logic [QW-1:0] push_data, pop_data;

  itda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (push),
    .q_ready   (push_ready),
    .q_data    (push_data)
  );

  itda_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  itda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ verif/integer_to_decimal_ascii_tb.sv @@
// Self-checking bench for the integer to decimal ASCII converter: words go in
// over a stream port, their decimal text is predicted and compared per character.
// Depends on itda_pkg and the integer_to_decimal_ascii top level.
module integer_to_decimal_ascii_tb;
  import itda_pkg::*;

  localparam int WORD_W = VALUE_BITS_DEF;
  localparam int RADIX = 10;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_TAIL = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic op;
    bit jittery;  // idling allowed on both sides while this item is in flight
    bit drain;    // hold this item back until every pending character has come out
  } number_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic last;
    logic [COUNT_W-1:0] count;
  } char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [WORD_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  number_t pending_numbers[$];
  char_t expected_chars[$];
  number_t current;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int numbers_sent = 0;
  int negatives_sent = 0;
  int longest_sent = 0;
  int chars_seen = 0;

  integer_to_decimal_ascii #(.VALUE_BITS(WORD_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Appends the characters that one word prints as to the expected store.
  function automatic void predict_text(input logic [WORD_W-1:0] word, input logic op);
    logic [WORD_W-1:0] mag;
    logic [CHAR_W-1:0] digits[$];
    bit negative;
    int total;
    char_t c;
    negative = (op == OP_SIGNED) && word[WORD_W-1];
    // The two's complement negation is done unsigned, so the most negative
    // value keeps its full magnitude.
    mag = negative ? (~word + 1'b1) : word;
    do begin
      digits.push_front(CH_ZERO + CHAR_W'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    total = digits.size() + (negative ? 1 : 0);
    if (negative) begin
      c.ch = CH_MINUS;
      c.last = (total == 1);
      c.count = COUNT_W'(total);
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch = digits[i];
      c.last = (i == digits.size() - 1);
      c.count = COUNT_W'(total);
      expected_chars.push_back(c);
    end
    numbers_sent++;
    if (negative) negatives_sent++;
    if (total == 11) longest_sent++;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, WORD_W - 1);
      2: begin
        // Around a power of ten, where the digit count changes.
        repeat ($urandom_range(0, 9)) p = p * RADIX;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return -WORD_W'($urandom_range(1, 1000));
      4: return $urandom_range(0, 99);
      default: begin
        if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
    endcase
  endfunction

  task automatic add_number(input logic [WORD_W-1:0] value, input logic op,
                            input bit jittery, input bit drain);
    number_t n;
    n.value = value;
    n.op = op;
    n.jittery = jittery;
    n.drain = drain;
    pending_numbers.push_back(n);
  endtask

  initial begin
    bit jittery;
    logic [WORD_W-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'd9, 32'd10, 32'hAAAA_AAAA, 32'h5555_5555, 32'd999_999_999,
                 32'd1_000_000_000};
    // Every directed word goes in once as signed and once as unsigned.
    foreach (directed[i]) begin
      add_number(directed[i], OP_SIGNED, 1'b1, 1'b0);
      add_number(directed[i], OP_UNSIGNED, 1'b1, 1'b0);
    end
    jittery = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) jittery = ($urandom_range(0, 3) != 0);
      add_number(random_word(), 1'($urandom_range(0, 1)),
                 jittery && (i < RANDOM_ITEMS - CALM_TAIL), (i == 0) || (i == 150));
    end
  end

  // Sender: holds an item until it is taken, with occasional short random gaps after jittery items.
  always @(posedge clk) begin : send_numbers
    bit fire;
    number_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) predict_text(current.value, current.op);
      if (in_tvalid && !fire) begin
        in_tvalid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_numbers.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_numbers[0].drain && expected_chars.size() != 0) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = pending_numbers.pop_front();
        current = nxt;
        in_tdata <= nxt.value;
        in_tuser <= nxt.op;
        in_tvalid <= 1'b1;
        calm <= !nxt.jittery;
        if (nxt.jittery && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
      end
    end
  end

  // Receiver: stalls in random bursts unless the run is calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_chars
    char_t want;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected character: char=%h last=%b count=%0d",
                   out_tdata[CHAR_W-1:0], out_tlast, out_tdata[CHAR_W +: COUNT_W]);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[CHAR_W-1:0] !== want.ch || out_tlast !== want.last ||
            out_tdata[CHAR_W +: COUNT_W] !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected char=%h last=%b count=%0d, got char=%h last=%b count=%0d",
                     want.ch, want.last, want.count, out_tdata[CHAR_W-1:0], out_tlast,
                     out_tdata[CHAR_W +: COUNT_W]);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while ((pending_numbers.size() != 0 || in_tvalid || expected_chars.size() != 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d characters outstanding", expected_chars.size());
      $display("[FAIL] regression broken");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (expected_chars.size() != 0) mismatches++;
      $display("Converted %0d numbers (%0d negative, %0d of eleven characters),",
               numbers_sent, negatives_sent, longest_sent);
      $display("checked %0d characters, %0d mismatches.", chars_seen, mismatches);
      if (mismatches == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule
